@@ hw/rtl/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and codes for the checksummed frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned WORD16_W   = 16;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned ERR_W      = 3;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd85;
   localparam logic [BYTE_W-1:0] EXT_LINGO_RST  = 8'd4;

   // header bytes counted by the length field: lingo, command, trans id
   localparam logic [WORD16_W-1:0] HDR_LEN_SHORT = 16'd4;
   localparam logic [WORD16_W-1:0] HDR_LEN_EXT   = 16'd5;

   // packed widths of the result word
   localparam int unsigned RSP_DATA_BITS = 3 * BYTE_W + 2 * WORD16_W - BYTE_W + ERR_W;
   localparam int unsigned RSP_DATA_W    = ((RSP_DATA_BITS + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_BYTE = 1'd0,
      CSR_EXT_LINGO  = 1'd1
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_GOOD     = 3'd0,
      ERR_START    = 3'd1,
      ERR_CHECKSUM = 3'd2,
      ERR_TRUNC    = 3'd3,
      ERR_SHORT    = 3'd4
   } error_type;

   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_LEN1    = 4'd1,
      PH_LENHI   = 4'd2,
      PH_LENLO   = 4'd3,
      PH_LINGO   = 4'd4,
      PH_CMDHI   = 4'd5,
      PH_CMDLO   = 4'd6,
      PH_TIDHI   = 4'd7,
      PH_TIDLO   = 4'd8,
      PH_PAYLOAD = 4'd9,
      PH_TRAIL   = 4'd10,
      PH_DRAIN   = 4'd11
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BYTE_W-1:0]   lingo;
      logic [WORD16_W-1:0] command;
      logic [WORD16_W-1:0] txn_id;
      logic [BYTE_W-1:0]   payload_byte;
      logic                payload_last;
      logic [ERR_W-1:0]    error;
   } result_type;

endpackage

@@ hw/rtl/cfd_parser.sv @@
// ----------------------------------------------------------------------------
// cfd_parser
// Per-byte frame state machine, checksum, header capture and result build.
// ----------------------------------------------------------------------------
module cfd_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_accept,
   input  logic [cfd_pkg::BYTE_W-1:0]          data_byte,
   input  logic                                end_of_frame,
   input  logic                                csr_we,
   input  logic [cfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cfd_pkg::BYTE_W-1:0]          csr_data,
   output logic                                res_valid,
   output cfd_pkg::result_type                 res_data
);

   cfd_pkg::phase_type              phase_ff, phase_in;
   logic [cfd_pkg::BYTE_W-1:0]      start_byte_ff, ext_lingo_ff;
   logic [cfd_pkg::BYTE_W-1:0]      sum_ff, sum_in;
   logic [cfd_pkg::WORD16_W-1:0]    length_ff, length_in;
   logic [cfd_pkg::WORD16_W-1:0]    left_ff, left_in;
   logic [cfd_pkg::BYTE_W-1:0]      lingo_ff, lingo_in;
   logic [cfd_pkg::WORD16_W-1:0]    command_ff, command_in;
   logic [cfd_pkg::WORD16_W-1:0]    tid_ff, tid_in;
   cfd_pkg::error_type              pend_ff, pend_in;

   logic [cfd_pkg::BYTE_W-1:0]      sum_next;
   logic [cfd_pkg::WORD16_W-1:0]    need;
   logic [cfd_pkg::WORD16_W-1:0]    left_dec;
   logic                            is_ext;
   logic                            too_short;
   cfd_pkg::error_type              status_err;

   assign sum_next  = sum_ff + data_byte;
   assign is_ext    = (data_byte == ext_lingo_ff);
   assign need      = is_ext ? cfd_pkg::HDR_LEN_EXT : cfd_pkg::HDR_LEN_SHORT;
   assign too_short = (length_ff < need);
   assign left_dec  = left_ff - 16'd1;

   // status code for the last byte of the buffer, highest priority first
   always_comb begin
      if (phase_ff == cfd_pkg::PH_START) begin
         status_err = (data_byte != start_byte_ff) ? cfd_pkg::ERR_START : cfd_pkg::ERR_TRUNC;
      end else if (pend_ff == cfd_pkg::ERR_START) begin
         status_err = cfd_pkg::ERR_START;
      end else if (sum_next != '0) begin
         status_err = cfd_pkg::ERR_CHECKSUM;
      end else if (pend_ff == cfd_pkg::ERR_SHORT) begin
         status_err = cfd_pkg::ERR_SHORT;
      end else if (phase_ff != cfd_pkg::PH_TRAIL) begin
         status_err = cfd_pkg::ERR_TRUNC;
      end else begin
         status_err = cfd_pkg::ERR_GOOD;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_accept) begin
         if (end_of_frame) begin
            phase_in = cfd_pkg::PH_START;
         end else begin
            unique case (phase_ff)
               cfd_pkg::PH_START:
                  phase_in = (data_byte != start_byte_ff) ? cfd_pkg::PH_DRAIN
                                                          : cfd_pkg::PH_LEN1;
               cfd_pkg::PH_LEN1:
                  phase_in = (data_byte != '0) ? cfd_pkg::PH_LINGO : cfd_pkg::PH_LENHI;
               cfd_pkg::PH_LENHI: phase_in = cfd_pkg::PH_LENLO;
               cfd_pkg::PH_LENLO: phase_in = cfd_pkg::PH_LINGO;
               cfd_pkg::PH_LINGO: begin
                  if (too_short) begin
                     phase_in = cfd_pkg::PH_DRAIN;
                  end else begin
                     phase_in = is_ext ? cfd_pkg::PH_CMDHI : cfd_pkg::PH_CMDLO;
                  end
               end
               cfd_pkg::PH_CMDHI: phase_in = cfd_pkg::PH_CMDLO;
               cfd_pkg::PH_CMDLO: phase_in = cfd_pkg::PH_TIDHI;
               cfd_pkg::PH_TIDHI: phase_in = cfd_pkg::PH_TIDLO;
               cfd_pkg::PH_TIDLO:
                  phase_in = (left_ff == '0) ? cfd_pkg::PH_TRAIL : cfd_pkg::PH_PAYLOAD;
               cfd_pkg::PH_PAYLOAD:
                  phase_in = (left_dec == '0) ? cfd_pkg::PH_TRAIL : cfd_pkg::PH_PAYLOAD;
               cfd_pkg::PH_TRAIL: phase_in = cfd_pkg::PH_TRAIL;
               cfd_pkg::PH_DRAIN: phase_in = cfd_pkg::PH_DRAIN;
               default:           phase_in = cfd_pkg::PH_START;
            endcase
         end
      end
   end

   // datapath and result
   always_comb begin
      sum_in     = sum_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      lingo_in   = lingo_ff;
      command_in = command_ff;
      tid_in     = tid_ff;
      pend_in    = pend_ff;

      res_valid             = 1'b0;
      res_data.kind         = cfd_pkg::KIND_HEADER;
      res_data.lingo        = lingo_ff;
      res_data.command      = command_ff;
      res_data.txn_id       = tid_ff;
      res_data.payload_byte = '0;
      res_data.payload_last = 1'b0;
      res_data.error        = cfd_pkg::ERR_GOOD;

      if (in_accept) begin
         if (end_of_frame) begin
            res_valid      = 1'b1;
            res_data.kind  = cfd_pkg::KIND_STATUS;
            res_data.error = status_err;
            sum_in     = '0;
            length_in  = '0;
            left_in    = '0;
            lingo_in   = '0;
            command_in = '0;
            tid_in     = '0;
            pend_in    = cfd_pkg::ERR_GOOD;
         end else if (phase_ff == cfd_pkg::PH_START) begin
            if (data_byte != start_byte_ff) begin
               pend_in = cfd_pkg::ERR_START;
            end
         end else begin
            sum_in = sum_next;
            unique case (phase_ff)
               cfd_pkg::PH_LEN1: begin
                  if (data_byte != '0) begin
                     length_in = {8'd0, data_byte};
                  end
               end
               cfd_pkg::PH_LENHI: length_in = {data_byte, 8'd0};
               cfd_pkg::PH_LENLO: length_in = {length_ff[15:8], data_byte};
               cfd_pkg::PH_LINGO: begin
                  lingo_in   = data_byte;
                  command_in = '0;
                  if (too_short) begin
                     pend_in = cfd_pkg::ERR_SHORT;
                  end else begin
                     left_in = length_ff - need;
                  end
               end
               cfd_pkg::PH_CMDHI: command_in = {data_byte, 8'd0};
               cfd_pkg::PH_CMDLO: command_in = {command_ff[15:8], data_byte};
               cfd_pkg::PH_TIDHI: tid_in = {data_byte, 8'd0};
               cfd_pkg::PH_TIDLO: begin
                  tid_in            = {tid_ff[15:8], data_byte};
                  res_valid         = 1'b1;
                  res_data.txn_id   = {tid_ff[15:8], data_byte};
               end
               cfd_pkg::PH_PAYLOAD: begin
                  left_in               = left_dec;
                  res_valid             = 1'b1;
                  res_data.kind         = cfd_pkg::KIND_PAYLOAD;
                  res_data.payload_byte = data_byte;
                  res_data.payload_last = (left_dec == '0);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= cfd_pkg::PH_START;
         start_byte_ff <= cfd_pkg::START_BYTE_RST;
         ext_lingo_ff  <= cfd_pkg::EXT_LINGO_RST;
         sum_ff        <= '0;
         length_ff     <= '0;
         left_ff       <= '0;
         lingo_ff      <= '0;
         command_ff    <= '0;
         tid_ff        <= '0;
         pend_ff       <= cfd_pkg::ERR_GOOD;
      end else begin
         phase_ff   <= phase_in;
         sum_ff     <= sum_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
         lingo_ff   <= lingo_in;
         command_ff <= command_in;
         tid_ff     <= tid_in;
         pend_ff    <= pend_in;
         if (csr_we) begin
            unique case (cfd_pkg::csr_index_type'(csr_index))
               cfd_pkg::CSR_START_BYTE: start_byte_ff <= csr_data;
               cfd_pkg::CSR_EXT_LINGO:  ext_lingo_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

@@ hw/rtl/cfd_out_reg.sv @@
// ----------------------------------------------------------------------------
// cfd_out_reg
// Result register; frees itself in the same cycle the word is taken.
// ----------------------------------------------------------------------------
module cfd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cfd_pkg::result_type  load_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cfd_pkg::result_type  out_data
);

   logic                 valid_ff, valid_in;
   cfd_pkg::result_type  data_ff;

   assign space     = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ hw/rtl/checksummed_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// checksummed_frame_deframer
// Length-prefixed frame parser with 8-bit additive checksum check.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          contents
//  req      in         tvalid/tready      one received byte, tlast on last byte
//  rsp      out        tvalid/tready      header, payload byte or frame status
//  csr      in         we                 start byte, extended lingo
//
//  One byte per cycle while rsp is not stalled; every result is produced in the cycle its byte is
//  taken and sits in the result register in the next cycle.
//  Throughput is set by the single result register: a byte is taken whenever
//  that register is empty or being drained in the same cycle.
//  Synchronous reset restores both registers and returns to the start byte.
//  A stalled rsp side holds the result and blocks req until it is taken.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // data_byte
   input  logic                              req_tlast,   // end_of_frame
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // lingo, command, txn_id, payload_byte, error, zero fill
   output logic [cfd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [cfd_pkg::KIND_W-1:0]        rsp_tuser,   // kind
   output logic                              rsp_tlast,   // payload_last
   input  logic                              csr_we,
   input  logic [cfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cfd_pkg::BYTE_W-1:0]        csr_data
);

   logic                 accept;
   logic                 res_valid;
   logic                 space;
   cfd_pkg::result_type  res_data;
   cfd_pkg::result_type  out_data;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   cfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (accept),
      .data_byte    (req_tdata),
      .end_of_frame (req_tlast),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .res_valid    (res_valid),
      .res_data     (res_data)
   );

   cfd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res_data),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.payload_last;
   assign rsp_tdata = {{(cfd_pkg::RSP_DATA_W - cfd_pkg::RSP_DATA_BITS){1'b0}},
                       out_data.error,
                       out_data.payload_byte,
                       out_data.txn_id,
                       out_data.command,
                       out_data.lingo};

endmodule

@@ tb/tb_checksummed_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checksummed_frame_deframer
// Self-checking bench for the checksummed frame deframer. Builds frames
// (good, bad start, bad checksum, truncated, short length, noise), runs a
// byte-level predictor of the parser on every byte taken and compares each
// result word against the oldest predicted report, with random stalls on
// both channels and start byte / extended lingo swept through their extremes.
// ----------------------------------------------------------------------------
module tb_checksummed_frame_deframer;

   localparam int unsigned CYCLE_LIMIT = 400000;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;   // data_byte
   logic                            req_tlast;   // end_of_frame
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // lingo, command, txn_id, payload_byte, error, zero fill
   logic [cfd_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [cfd_pkg::KIND_W-1:0]      rsp_tuser;   // kind
   logic                            rsp_tlast;   // payload_last
   logic                            csr_we;
   logic [cfd_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [cfd_pkg::BYTE_W-1:0]      csr_data;

   checksummed_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor copy of the parser
   logic [7:0]           cfg_start;
   logic [7:0]           cfg_ext;
   cfd_pkg::phase_type   ph;
   logic [7:0]           run_sum;
   logic [15:0]          flen;
   logic [15:0]          left;
   logic [7:0]           held_lingo;
   logic [15:0]          held_cmd;
   logic [15:0]          held_tid;
   cfd_pkg::error_type   perr;

   cfd_pkg::result_type  reports_due[$];
   logic [7:0]           frame_q[$];

   int unsigned  items_sent;
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   bit           quiet;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 16);
   end

   // result checker
   always @(posedge clock) begin
      cfd_pkg::result_type got;
      cfd_pkg::result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind         = rsp_tuser;
         got.lingo        = rsp_tdata[7:0];
         got.command      = rsp_tdata[23:8];
         got.txn_id       = rsp_tdata[39:24];
         got.payload_byte = rsp_tdata[47:40];
         got.payload_last = rsp_tlast;
         got.error        = rsp_tdata[50:48];
         if (reports_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display({"unexpected word: kind=%0d lingo=%h cmd=%h tid=%h pay=%h",
                         " last=%b err=%0d"},
                        got.kind, got.lingo, got.command, got.txn_id,
                        got.payload_byte, got.payload_last, got.error);
         end else begin
            exp = reports_due.pop_front();
            if (got !== exp) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch exp: kind=%0d lingo=%h cmd=%h tid=%h pay=%h last=%b err=%0d",
                           exp.kind, exp.lingo, exp.command, exp.txn_id,
                           exp.payload_byte, exp.payload_last, exp.error);
                  $display("         got: kind=%0d lingo=%h cmd=%h tid=%h pay=%h last=%b err=%0d",
                           got.kind, got.lingo, got.command, got.txn_id,
                           got.payload_byte, got.payload_last, got.error);
               end
            end
         end
      end
   end

   task automatic clear_frame();
      ph         = cfd_pkg::PH_START;
      run_sum    = '0;
      flen       = '0;
      left       = '0;
      held_lingo = '0;
      held_cmd   = '0;
      held_tid   = '0;
      perr       = cfd_pkg::ERR_GOOD;
   endtask

   task automatic add_byte(input logic [7:0] b);
      frame_q.insert(frame_q.size(), b);
   endtask

   task automatic add_report(input cfd_pkg::kind_type k, input logic [7:0] pbyte,
                             input logic plast, input cfd_pkg::error_type e);
      cfd_pkg::result_type r;
      r.kind         = k;
      r.lingo        = held_lingo;
      r.command      = held_cmd;
      r.txn_id       = held_tid;
      r.payload_byte = pbyte;
      r.payload_last = plast;
      r.error        = e;
      reports_due.insert(reports_due.size(), r);
   endtask

   task automatic deframe_byte(input logic [7:0] b, input logic eof);
      logic [7:0]          s;
      logic [15:0]         need;
      cfd_pkg::error_type  e;
      if (eof) begin
         if (ph == cfd_pkg::PH_START) begin
            e = (b != cfg_start) ? cfd_pkg::ERR_START : cfd_pkg::ERR_TRUNC;
         end else begin
            s = run_sum + b;
            if (perr == cfd_pkg::ERR_START)      e = cfd_pkg::ERR_START;
            else if (s != 8'h00)                 e = cfd_pkg::ERR_CHECKSUM;
            else if (perr == cfd_pkg::ERR_SHORT) e = cfd_pkg::ERR_SHORT;
            else if (ph != cfd_pkg::PH_TRAIL)    e = cfd_pkg::ERR_TRUNC;
            else                                 e = cfd_pkg::ERR_GOOD;
         end
         add_report(cfd_pkg::KIND_STATUS, 8'h00, 1'b0, e);
         clear_frame();
      end else if (ph == cfd_pkg::PH_START) begin
         if (b != cfg_start) begin
            perr = cfd_pkg::ERR_START;
            ph   = cfd_pkg::PH_DRAIN;
         end else begin
            ph = cfd_pkg::PH_LEN1;
         end
      end else begin
         run_sum = run_sum + b;
         case (ph)
            cfd_pkg::PH_LEN1: begin
               if (b != 8'h00) begin
                  flen = {8'h00, b};
                  ph   = cfd_pkg::PH_LINGO;
               end else begin
                  ph = cfd_pkg::PH_LENHI;
               end
            end
            cfd_pkg::PH_LENHI: begin
               flen = {b, 8'h00};
               ph   = cfd_pkg::PH_LENLO;
            end
            cfd_pkg::PH_LENLO: begin
               flen = {flen[15:8], b};
               ph   = cfd_pkg::PH_LINGO;
            end
            cfd_pkg::PH_LINGO: begin
               need       = (b == cfg_ext) ? cfd_pkg::HDR_LEN_EXT : cfd_pkg::HDR_LEN_SHORT;
               held_lingo = b;
               held_cmd   = '0;
               if (flen < need) begin
                  perr = cfd_pkg::ERR_SHORT;
                  ph   = cfd_pkg::PH_DRAIN;
               end else begin
                  left = flen - need;
                  ph   = (b == cfg_ext) ? cfd_pkg::PH_CMDHI : cfd_pkg::PH_CMDLO;
               end
            end
            cfd_pkg::PH_CMDHI: begin
               held_cmd = {b, 8'h00};
               ph       = cfd_pkg::PH_CMDLO;
            end
            cfd_pkg::PH_CMDLO: begin
               held_cmd = {held_cmd[15:8], b};
               ph       = cfd_pkg::PH_TIDHI;
            end
            cfd_pkg::PH_TIDHI: begin
               held_tid = {b, 8'h00};
               ph       = cfd_pkg::PH_TIDLO;
            end
            cfd_pkg::PH_TIDLO: begin
               held_tid = {held_tid[15:8], b};
               ph       = (left == 16'd0) ? cfd_pkg::PH_TRAIL : cfd_pkg::PH_PAYLOAD;
               add_report(cfd_pkg::KIND_HEADER, 8'h00, 1'b0, cfd_pkg::ERR_GOOD);
            end
            cfd_pkg::PH_PAYLOAD: begin
               left = left - 16'd1;
               if (left == 16'd0) ph = cfd_pkg::PH_TRAIL;
               add_report(cfd_pkg::KIND_PAYLOAD, b, left == 16'd0, cfd_pkg::ERR_GOOD);
            end
            default: begin
            end
         endcase
      end
   endtask

   // entered and left at a falling edge; leaves tvalid high for the next word
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!quiet && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      deframe_byte(b, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // hold off until every report is in and the parser has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (reports_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input cfd_pkg::csr_index_type idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      if (idx == cfd_pkg::CSR_START_BYTE) cfg_start = value;
      else                                cfg_ext   = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // frame in frame_q; trailing bytes end with the byte that zeroes the sum
   task automatic build_frame(input logic [7:0] lng, input logic [15:0] cmd,
                              input logic [15:0] tid, input int plen, input int len_delta,
                              input bit force_long, input int trail);
      int          n;
      logic [15:0] fl;
      logic [7:0]  s;
      n = ((lng == cfg_ext) ? 5 : 4) + plen + len_delta;
      if (n < 0) n = 0;
      if (n > 65535) n = 65535;
      fl = n[15:0];
      frame_q.delete();
      add_byte(cfg_start);
      if (force_long || fl == 16'd0 || fl > 16'd255) begin
         add_byte(8'h00);
         add_byte(fl[15:8]);
         add_byte(fl[7:0]);
      end else begin
         add_byte(fl[7:0]);
      end
      add_byte(lng);
      if (lng == cfg_ext) add_byte(cmd[15:8]);
      add_byte(cmd[7:0]);
      add_byte(tid[15:8]);
      add_byte(tid[7:0]);
      repeat (plen) add_byte(8'($urandom_range(0, 255)));
      repeat (trail - 1) add_byte(8'($urandom_range(0, 255)));
      s = 8'h00;
      for (int i = 1; i < frame_q.size(); i++) s = s + frame_q[i];
      add_byte(8'h00 - s);
   endtask

   task automatic random_frame();
      logic [7:0] lng;
      int         plen;
      int         sel;
      int         cut;
      int         hdr;
      lng  = ($urandom_range(0, 3) == 0) ? cfg_ext : 8'($urandom_range(0, 255));
      hdr  = (lng == cfg_ext) ? 5 : 4;
      plen = ($urandom_range(0, 99) < 3) ? $urandom_range(256, 300) : $urandom_range(0, 12);
      sel  = $urandom_range(0, 99);
      if (sel < 90)
         build_frame(lng, 16'($urandom), 16'($urandom), plen,
                     (sel >= 85) ? $urandom_range(0, 6) - 3 : 0,
                     $urandom_range(0, 4) == 0,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : 1);
      if (sel >= 65 && sel < 72) begin
         // bad checksum
         frame_q[frame_q.size() - 1] ^= 8'($urandom_range(1, 255));
      end else if (sel >= 72 && sel < 80) begin
         // truncated buffer
         cut = $urandom_range(1, frame_q.size() - 1);
         while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else if (sel >= 80 && sel < 85) begin
         frame_q[0] ^= 8'($urandom_range(1, 255));
      end else if (sel >= 90 && sel < 95) begin
         // length below the header size, zero included
         build_frame(lng, 16'($urandom), 16'($urandom), 0, -$urandom_range(1, hdr),
                     $urandom_range(0, 1), 1);
      end else if (sel >= 95) begin
         frame_q.delete();
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end
      send_frame();
   endtask

   task automatic test_directed();
      // lone start byte, then bad start with a follower
      frame_q = '{cfg_start};
      send_frame();
      frame_q = '{cfg_start ^ 8'h01, 8'hFF};
      send_frame();
      build_frame(8'h00, 16'h00FF, 16'hFFFF, 0, 0, 0, 1);
      send_frame();
      build_frame(cfg_ext, 16'hFFFF, 16'h0000, 1, 0, 0, 1);
      send_frame();
      // zero length in long form
      build_frame(8'hFF, 16'h0012, 16'h3456, 0, -4, 1, 1);
      send_frame();
   endtask

   task automatic test_config_sweep();
      logic [7:0] start_vals[3];
      logic [7:0] ext_vals[3];
      start_vals = '{8'h00, 8'hFF, 8'($urandom_range(1, 254))};
      ext_vals   = '{8'hFF, 8'h00, 8'($urandom_range(1, 254))};
      for (int i = 0; i < 3; i++) begin
         wait_idle();
         write_csr(cfd_pkg::CSR_START_BYTE, start_vals[i]);
         write_csr(cfd_pkg::CSR_EXT_LINGO, ext_vals[i]);
         repeat (4) random_frame();
      end
   endtask

   task automatic test_idle_pressure();
      repeat (6) begin
         random_frame();
         wait_idle();
      end
   endtask

   task automatic test_random_frames(input int unsigned count);
      int unsigned first;
      first = items_sent;
      while (items_sent - first < count) begin
         quiet = (items_sent - first >= 200) && (items_sent - first < 350);
         random_frame();
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = cfd_pkg::CSR_START_BYTE;
      csr_data       = '0;
      quiet          = 1'b0;
      items_sent     = 0;
      cfg_start      = cfd_pkg::START_BYTE_RST;
      cfg_ext        = cfd_pkg::EXT_LINGO_RST;
      clear_frame();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_config_sweep();
      test_idle_pressure();
      test_random_frames(500);

      wait_idle();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && reports_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
